/* rtl/core/int_to_ascii_formatter_assert.svh */
// Assertion macros used by the formatter checker.
`ifndef INT_TO_ASCII_FORMATTER_ASSERT_SVH
`define INT_TO_ASCII_FORMATTER_ASSERT_SVH

// Clocked assertion, muted while reset is applied.
`define ITAF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ITAF_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* rtl/core/itaf_pkg.sv */
// Shared types, constants and helpers of the integer to ASCII formatter.
`timescale 1ns / 1ps
package itaf_pkg;

  localparam int unsigned MAX_CHARS_DEF = 30;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_RADIX = 2'd0,
    REG_FRAC  = 2'd1,
    REG_WIDTH = 2'd2,
    REG_FILL  = 2'd3
  } reg_idx_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } item_t;

  // Active configuration seen by the back end
  typedef struct packed {
    logic [4:0] radix;
    logic [4:0] frac;
    logic [4:0] min_width;
    logic [7:0] fill;
  } cfg_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'd0, d};
    else           c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage

/* rtl/core/itaf_front.sv */
// Front end: accepts values, splits sign and magnitude, queues them.
`timescale 1ns / 1ps
module itaf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         value_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output itaf_pkg::item_t     item_o
);
  import itaf_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;
  item_t      cls;

  // Sign and unsigned magnitude; the most negative value wraps correctly
  always_comb begin
    cls.neg = value_i[31];
    cls.mag = value_i[31] ? (32'd0 - value_i) : value_i;
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_wr        = push && !full;
  assign do_rd        = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

/* rtl/core/itaf_back.sv */
// Back end: digit generation by repeated division, string build, emission.
`timescale 1ns / 1ps
module itaf_back #(
  parameter int unsigned MAX_CHARS = itaf_pkg::MAX_CHARS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itaf_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  itaf_pkg::item_t     item_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          char_code_o,
  output logic                last_char_o,
  output logic                truncated_o
);
  import itaf_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CHARS);
  localparam int unsigned NW = $clog2(MAX_CHARS + 40);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_PUSH = 9'b000000100,
    S_POST = 9'b000001000,
    S_ZPAD = 9'b000010000,
    S_ZERO = 9'b000100000,
    S_SIGN = 9'b001000000,
    S_FILL = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [31:0]   mag_q, mag_d;
  logic [3:0]    rem_q, rem_d;
  logic [1:0]    step_q, step_d;
  logic          neg_q, neg_d;
  logic [NW-1:0] n_q, n_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          trunc_q, trunc_d;
  logic          outv_q;
  logic [7:0]    out_char_q;
  logic          out_last_q, out_trunc_q;
  logic [7:0]    buf_q [MAX_CHARS];
  logic          wr_en;
  logic [7:0]    wr_char;
  logic [NW-1:0] wr_idx;
  logic          load_out;
  logic [31:0]   dm;
  logic [3:0]    dr;
  logic [4:0]    dt;
  logic [NW-1:0] frac_n, width_n, max_n, cnt;

  assign frac_n  = NW'(cfg_i.frac);
  assign width_n = NW'(cfg_i.min_width);
  assign max_n   = NW'(MAX_CHARS);
  assign cnt     = (n_q > max_n) ? max_n : n_q;

  // Eight restoring division steps per cycle on the shifting dividend
  always_comb begin
    dm = mag_q;
    dr = rem_q;
    dt = 5'd0;
    for (int i = 0; i < 8; i++) begin
      dt = {dr, dm[31]};
      if (dt >= cfg_i.radix) begin
        dt = dt - cfg_i.radix;
        dm = {dm[30:0], 1'b1};
      end else begin
        dm = {dm[30:0], 1'b0};
      end
      dr = dt[3:0];
    end
  end

  assign item_ready_o = (state_q == S_IDLE);
  assign load_out     = (state_q == S_EMIT) && (!outv_q || pop);
  // A zero value writes its digit while the count is still that of the last string
  assign wr_idx       = (state_q == S_IDLE) ? '0 : n_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    step_d  = step_q;
    neg_d   = neg_q;
    n_d     = n_q;
    idx_d   = idx_q;
    trunc_d = trunc_q;
    wr_en   = 1'b0;
    wr_char = CH_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          neg_d  = item_i.neg;
          mag_d  = item_i.mag;
          rem_d  = 4'd0;
          step_d = 2'd0;
          if (item_i.mag == 32'd0) begin
            wr_en   = 1'b1;
            n_d     = NW'(1);
            state_d = S_POST;
          end else begin
            n_d     = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        mag_d  = dm;
        rem_d  = dr;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = S_PUSH;
      end
      S_PUSH: begin
        wr_en = 1'b1;
        n_d   = n_q + NW'(1);
        if (cfg_i.frac != 5'd0 && n_q == frac_n) begin
          wr_char = CH_DOT;
        end else begin
          wr_char = digit_char(rem_q);
          rem_d   = 4'd0;
          step_d  = 2'd0;
          state_d = (mag_q == 32'd0) ? S_POST : S_DIV;
        end
      end
      S_POST: begin
        state_d = (n_q <= frac_n) ? S_ZPAD : S_SIGN;
      end
      S_ZPAD: begin
        wr_en = 1'b1;
        n_d   = n_q + NW'(1);
        if (n_q < frac_n) begin
          wr_char = CH_ZERO;
        end else begin
          wr_char = CH_DOT;
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        wr_en   = 1'b1;
        n_d     = n_q + NW'(1);
        state_d = S_SIGN;
      end
      S_SIGN: begin
        if (neg_q) begin
          wr_en   = 1'b1;
          wr_char = CH_MINUS;
          n_d     = n_q + NW'(1);
        end
        state_d = S_FILL;
      end
      S_FILL: begin
        if (n_q < width_n) begin
          wr_en   = 1'b1;
          wr_char = cfg_i.fill;
          n_d     = n_q + NW'(1);
        end else begin
          trunc_d = (n_q > max_n);
          idx_d   = IW'(cnt - NW'(1));
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          if (idx_q == '0) state_d = S_IDLE;
          else             idx_d   = idx_q - IW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Character buffer, least significant first; only the kept tail is stored
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_idx < max_n) begin
      buf_q[wr_idx[IW-1:0]] <= wr_char;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    neg_q   <= neg_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    trunc_q <= trunc_d;
    if (load_out) begin
      out_char_q  <= buf_q[idx_q];
      out_last_q  <= (idx_q == '0);
      out_trunc_q <= trunc_q;
    end
  end

  // Control state and output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)  outv_q <= 1'b1;
      else if (pop)  outv_q <= 1'b0;
    end
  end

  assign empty       = !outv_q;
  assign char_code_o = out_char_q;
  assign last_char_o = out_last_q;
  assign truncated_o = out_trunc_q;

endmodule

/* rtl/core/int_to_ascii_formatter.sv */
// Top level of the signed integer to ASCII formatter.
//
//  channel | ports                                   | transaction when
//  input   | push, full, value_i                     | push && !full
//  result  | empty, pop, char_code_o, last_char_o,   | pop && !empty
//          | truncated_o                             |
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i         | cfg_we_i
//
// Each digit comes from passes of the 8-step divider, then a push; the
// extra characters (point, zeros, sign, fill) follow, then the string is
// emitted one character per cycle while the result side keeps popping.
// A two-entry queue holds values meanwhile.
// Reset returns the registers to radix 10, no point, no width, space fill.
// Either side may stall at any time without loss.
`timescale 1ns / 1ps
module int_to_ascii_formatter #(
  parameter int unsigned MAX_CHARS = itaf_pkg::MAX_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_code_o,
  output logic        last_char_o,
  output logic        truncated_o
);
  import itaf_pkg::*;

  logic [4:0] radix_q, frac_q, width_q;
  logic [7:0] fill_q;
  cfg_t       cfg;
  item_t      item;
  logic       item_valid, item_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= 5'd10;
      frac_q  <= 5'd0;
      width_q <= 5'd0;
      fill_q  <= 8'd32;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RADIX: radix_q <= cfg_data_i[4:0];
        REG_FRAC:  frac_q  <= cfg_data_i[4:0];
        REG_WIDTH: width_q <= cfg_data_i[4:0];
        REG_FILL:  fill_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Radix clamped to 2..16
  always_comb begin
    cfg.radix     = (radix_q < 5'd2) ? 5'd2 : ((radix_q > 5'd16) ? 5'd16 : radix_q);
    cfg.frac      = frac_q;
    cfg.min_width = width_q;
    cfg.fill      = fill_q;
  end

  itaf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  itaf_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .empty        (empty),
    .pop          (pop),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o),
    .truncated_o  (truncated_o)
  );

endmodule

/* rtl/core/itaf_checker.sv */
// Port-level checker for the formatter, bound to the top level.
`timescale 1ns / 1ps
`include "int_to_ascii_formatter_assert.svh"
module itaf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] char_code_o,
  input logic       last_char_o,
  input logic       truncated_o
);
  // Held result stays offered
  `ITAF_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> !empty)
  // Held result keeps its character
  `ITAF_ASSERT(a_stable, clk_i, rst_ni, (!empty && !pop) |=> $stable(char_code_o))
  // Output side is drained by reset
  `ITAF_ASSERT_RST(a_rst_empty, clk_i, !rst_ni |=> empty)
  // Truncation flag does not change within a string
  `ITAF_ASSERT(a_trunc, clk_i, rst_ni, (!empty && pop && !last_char_o) |=> (empty || $stable(truncated_o)))
endmodule

bind int_to_ascii_formatter itaf_checker u_itaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .char_code_o (char_code_o),
  .last_char_o (last_char_o),
  .truncated_o (truncated_o)
);

/* sim/int_to_ascii_formatter_test.sv */
// Self-checking testbench for the integer to ASCII formatter.
`timescale 1ns / 1ps
module int_to_ascii_formatter_test;
  import itaf_pkg::*;

  localparam int NCHARS = 30;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       trunc;
  } char_t;

  // Directed stimulus row; nexp is the length of the expected text
  typedef struct {
    logic [31:0] value;
    int          nexp;
    string       text;
    logic        trunc;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  char_code_o;
  logic        last_char_o;
  logic        truncated_o;

  // Shadow configuration
  logic [4:0] sh_radix = 5'd10;
  logic [4:0] sh_frac = 5'd0;
  logic [4:0] sh_width = 5'd0;
  logic [7:0] sh_fill = 8'd32;

  char_t expected_chars[$];
  int    error_count = 0;
  int    idle_cycles = 0;
  int    pop_idle_pct = 0;
  int    push_idle_pct = 0;

  int_to_ascii_formatter uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Builds the expected character string of one value
  task automatic format_value(input logic [31:0] v);
    logic [7:0]  rev[72];
    int          n;
    logic        neg;
    logic [31:0] mag;
    int          rad;
    int          frac;
    int          cnt;
    logic        tr;
    char_t       c;
    n = 0;
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    rad = sh_radix;
    frac = sh_frac;
    if (rad < 2) rad = 2;
    if (rad > 16) rad = 16;
    if (mag == 0) begin
      rev[n++] = "0";
    end else begin
      while (mag != 0 && n < 70) begin
        if (frac != 0 && n == frac) rev[n++] = ".";
        rev[n++] = digit_char(4'(mag % rad));
        mag = mag / rad;
      end
    end
    if (n <= frac) begin
      while (n < frac && n < 68) rev[n++] = "0";
      rev[n++] = ".";
      rev[n++] = "0";
    end
    if (neg) rev[n++] = "-";
    while (n < sh_width) rev[n++] = sh_fill;
    tr = n > NCHARS;
    cnt = tr ? NCHARS : n;
    for (int k = 0; k < cnt; k++) begin
      c.code = rev[cnt - 1 - k];
      c.last = (k == cnt - 1);
      c.trunc = tr;
      expected_chars.push_back(c);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_RADIX: sh_radix = data[4:0];
      REG_FRAC:  sh_frac = data[4:0];
      REG_WIDTH: sh_width = data[4:0];
      default:   sh_fill = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Registers change only once every value in flight has been emitted
  task automatic set_config(input int r, input int f, input int w, input int fc);
    drain();
    write_reg(REG_RADIX, 8'(r));
    write_reg(REG_FRAC, 8'(f));
    write_reg(REG_WIDTH, 8'(w));
    write_reg(REG_FILL, 8'(fc));
  endtask

  // Waits until all expected characters arrived, then lets the block settle
  task automatic drain;
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // One value transaction, with random idle before it; push stays high after
  // acceptance until the next idle cycle or drain
  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    format_value(v);
  endtask

  // Random value: half small magnitudes, a quarter full range, a quarter the two extremes
  function automatic logic [31:0] rand_value;
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: v = -$urandom_range(999);
      default: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
    return v;
  endfunction

  // Result side: pop at random and compare each transaction
  always @(posedge clk_i) begin
    char_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h", char_code_o));
        end else begin
          e = expected_chars.pop_front();
          if (char_code_o !== e.code)
            report_mismatch($sformatf("char_code %h, want %h", char_code_o, e.code));
          if (last_char_o !== e.last)
            report_mismatch($sformatf("last_char %b, want %b", last_char_o, e.last));
          if (truncated_o !== e.trunc)
            report_mismatch($sformatf("truncated %b, want %b", truncated_o, e.trunc));
        end
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("int_to_ascii_formatter_test: done, errors");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    string got;
    rows = '{
      '{32'd0, 1, "0", 1'b0},
      '{32'd7, 1, "7", 1'b0},
      '{32'hffff_ffff, 2, "-1", 1'b0},
      '{32'h7fff_ffff, 10, "2147483647", 1'b0},
      '{32'h8000_0000, 11, "-2147483648", 1'b0},
      '{32'd1234, 4, "1234", 1'b0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    push_idle_pct = 14;
    pop_idle_pct = 72;

    // Directed rows at reset configuration, literal expectations
    foreach (rows[i]) begin
      r = rows[i];
      send_value(r.value);
      got = "";
      for (int k = expected_chars.size() - r.nexp; k < expected_chars.size(); k++)
        got = {got, string'(expected_chars[k].code)};
      if (got != r.text || expected_chars[$].trunc != r.trunc)
        report_mismatch($sformatf("predictor gave %s for %s", got, r.text));
    end
    drain();

    // Extremes of radix, point, width and fill; predictor checked
    set_config(2, 0, 0, 32);
    send_value(32'h8000_0000);
    send_value(32'hffff_ffff);
    send_value(32'd0);
    set_config(16, 3, 8, 8'h2a);
    send_value(32'd5);
    send_value(32'hdead_beef);
    send_value(32'hffff_fff0);
    set_config(0, 28, 30, 8'hff);
    send_value(32'd0);
    send_value(32'hffff_ffff);
    set_config(31, 1, 31, 8'h00);
    send_value(32'd9);
    send_value(32'h7fff_ffff);
    set_config(10, 31, 0, 8'h55);
    send_value(32'd12);
    drain();

    // Random phases with changing idling
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        push_idle_pct = 72;
        pop_idle_pct = 14;
      end else if (ph == 6) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end
      case (ph % 3)
        0: set_config(10, 0, 0, 32);
        1: set_config($urandom_range(16, 2), $urandom_range(6), $urandom_range(12),
                      $urandom_range(255));
        default: set_config($urandom_range(31), $urandom_range(31), $urandom_range(31),
                            $urandom_range(255));
      endcase
      repeat (25) send_value(rand_value());
      drain();
    end

    if (error_count == 0) begin
      $display("int_to_ascii_formatter_test: done, clean");
    end else begin
      $display("int_to_ascii_formatter_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/itaf_pkg.sv
rtl/core/itaf_front.sv
rtl/core/itaf_back.sv
rtl/core/int_to_ascii_formatter.sv
rtl/core/itaf_checker.sv
sim/int_to_ascii_formatter_test.sv
